// ===== src/ladr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladr_pkg: shared types and constants of the light adaptive duty ramp
// Field widths, mode thresholds, base duties, offset tables and register
// indexes used by the channel interfaces and the top level.
// ----------------------------------------------------------------------------
package ladr_pkg;

  // Field widths
  localparam int LIGHT_W  = 8;
  localparam int DUTY_W   = 7;
  localparam int PERIOD_W = 8;
  localparam int TICK_W   = 8;
  localparam int STEP_W   = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_STEP_PERIOD  = 1'b0;
  localparam cfg_idx_t CFG_DUTY_CEILING = 1'b1;

  localparam logic [PERIOD_W-1:0] STEP_PERIOD_RST  = 8'd4;
  localparam logic [DUTY_W-1:0]   DUTY_CEILING_RST = 7'd100;

  // Number of steps in one ramp
  localparam logic [STEP_W-1:0] RAMP_STEPS = 4'd11;

  // Light thresholds for the mode choice
  localparam logic [LIGHT_W-1:0] LIGHT_DARK  = 8'd20;
  localparam logic [LIGHT_W-1:0] LIGHT_DUSK  = 8'd40;
  localparam logic [LIGHT_W-1:0] LIGHT_DIM   = 8'd50;
  localparam logic [LIGHT_W-1:0] LIGHT_MID   = 8'd70;

  // Base duties of the five light bands
  localparam logic [DUTY_W-1:0] BASE_NIGHT_DARK = 7'd15;
  localparam logic [DUTY_W-1:0] BASE_NIGHT_DUSK = 7'd20;
  localparam logic [DUTY_W-1:0] BASE_DAY_DIM    = 7'd42;
  localparam logic [DUTY_W-1:0] BASE_DAY_MID    = 7'd80;
  localparam logic [DUTY_W-1:0] BASE_DAY_BRIGHT = 7'd90;

  // Indicator lamps: bit 0 night lamp, bit 1 day lamp
  typedef logic [1:0] lamp_t;
  localparam lamp_t LAMPS_OFF = 2'b00;
  localparam lamp_t LAMP_NIGHT = 2'b01;
  localparam lamp_t LAMP_DAY   = 2'b10;

  // One result item
  typedef struct packed {
    logic              duty_update;
    logic [DUTY_W-1:0] duty;
    logic              night_indicator;
    logic              day_indicator;
    logic              busy_res;
  } ladr_res_t;

  // Night mode offset of one ramp step; steps past the table add nothing.
  function automatic logic [DUTY_W-1:0] night_offset(input logic [STEP_W-1:0] idx);
    logic [DUTY_W-1:0] val;
    case (idx)
      4'd0:    val = 7'd0;
      4'd1:    val = 7'd1;
      4'd2:    val = 7'd1;
      4'd3:    val = 7'd3;
      4'd4:    val = 7'd7;
      4'd5:    val = 7'd16;
      4'd6:    val = 7'd16;
      4'd7:    val = 7'd14;
      4'd8:    val = 7'd12;
      4'd9:    val = 7'd10;
      4'd10:   val = 7'd8;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

  // Day mode offset of one ramp step; steps past the table add nothing.
  function automatic logic [DUTY_W-1:0] day_offset(input logic [STEP_W-1:0] idx);
    logic [DUTY_W-1:0] val;
    case (idx)
      4'd0:    val = 7'd0;
      4'd1:    val = 7'd4;
      4'd2:    val = 7'd7;
      4'd3:    val = 7'd16;
      4'd4:    val = 7'd44;
      4'd5:    val = 7'd59;
      4'd6:    val = 7'd59;
      4'd7:    val = 7'd55;
      4'd8:    val = 7'd50;
      4'd9:    val = 7'd45;
      4'd10:   val = 7'd40;
      default: val = 7'd0;
    endcase
    return val;
  endfunction

endpackage

// ===== src/ladr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ladr_in_if / ladr_out_if: tick and result channels
// Valid/ready channels; an item moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ladr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         button_level;
  logic [ladr_pkg::LIGHT_W-1:0] light_level;

  modport source (output valid, output button_level, output light_level, input ready);
  modport sink   (input valid, input button_level, input light_level, output ready);
endinterface

interface ladr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        duty_update;
  logic [ladr_pkg::DUTY_W-1:0] duty;
  logic                        night_indicator;
  logic                        day_indicator;
  logic                        busy_res;

  modport source (output valid, output duty_update, output duty, output night_indicator,
                  output day_indicator, output busy_res, input ready);
  modport sink   (input valid, input duty_update, input duty, input night_indicator,
                  input day_indicator, input busy_res, output ready);
endinterface

// ===== src/light_adaptive_duty_ramp.sv =====
`timescale 1ns / 1ps
// A result item is registered in the two-entry output buffer: in its main slot,
// or in its skid slot while the main slot waits. One tick item is taken per
// cycle while the skid slot is empty; the ramp state is updated in the cycle
// the item is accepted. Reset (synchronous, active low) sets the ramp idle,
// both lamps off, step_period to 4, duty_ceiling to 100 and empties the buffer.
// ----------------------------------------------------------------------------
// light_adaptive_duty_ramp: button-started duty ramp with light-chosen mode
// A falling button edge picks night or day mode from the light level; every
// step_period ticks the next table offset is added to the base duty, capped
// at duty_ceiling and issued, until all ramp steps are done.
// ----------------------------------------------------------------------------
module light_adaptive_duty_ramp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ladr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ladr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ladr_in_if.sink                       in_ch,
  ladr_out_if.source                    out_ch
);
  import ladr_pkg::*;

  // Configuration registers
  logic [PERIOD_W-1:0] step_period_r;
  logic [DUTY_W-1:0]   duty_ceiling_r;

  // Ramp state
  logic                prev_btn_r, prev_btn_nxt;
  logic                running_r, running_nxt;
  logic [DUTY_W-1:0]   base_r, base_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  lamp_t               lamp_r, lamp_nxt;

  // Output buffer: main slot drives the port, skid slot catches one stall
  ladr_res_t           main_r, main_nxt, skid_r, skid_nxt;
  logic                main_vld_r, main_vld_nxt, skid_vld_r, skid_vld_nxt;

  logic                accept, pop, main_free;
  logic                press, night_pick, fire, done;
  logic [DUTY_W-1:0]   base_pick, offset, sat;
  logic [DUTY_W:0]     sum;
  logic [TICK_W-1:0]   tick_inc;
  logic [STEP_W-1:0]   step_inc;
  ladr_res_t           res;

  assign accept    = in_ch.valid && in_ch.ready;
  assign pop       = main_vld_r && out_ch.ready;
  assign main_free = !main_vld_r || pop;
  assign in_ch.ready = !skid_vld_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= STEP_PERIOD_RST;
      duty_ceiling_r <= DUTY_CEILING_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_STEP_PERIOD:  step_period_r  <= cfg_wdata[PERIOD_W-1:0];
        CFG_DUTY_CEILING: duty_ceiling_r <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Mode choice from the light level, used only on a press edge
  assign night_pick = in_ch.light_level <= LIGHT_DUSK;
  always_comb begin
    if (in_ch.light_level <= LIGHT_DARK) begin
      base_pick = BASE_NIGHT_DARK;
    end else if (in_ch.light_level <= LIGHT_DUSK) begin
      base_pick = BASE_NIGHT_DUSK;
    end else if (in_ch.light_level <= LIGHT_DIM) begin
      base_pick = BASE_DAY_DIM;
    end else if (in_ch.light_level <= LIGHT_MID) begin
      base_pick = BASE_DAY_MID;
    end else begin
      base_pick = BASE_DAY_BRIGHT;
    end
  end

  // Per-item ramp update: a press restarts, then the running tick is counted
  assign press = prev_btn_r && !in_ch.button_level;
  always_comb begin
    prev_btn_nxt = in_ch.button_level;
    running_nxt  = running_r;
    base_nxt     = base_r;
    tick_nxt     = tick_r;
    step_nxt     = step_r;
    lamp_nxt     = lamp_r;
    if (press) begin
      running_nxt = 1'b1;
      base_nxt    = base_pick;
      tick_nxt    = '0;
      step_nxt    = '0;
      lamp_nxt    = night_pick ? LAMP_NIGHT : LAMP_DAY;
    end

    tick_inc = tick_nxt + 1'b1;
    fire     = running_nxt && (tick_inc >= step_period_r);
    offset   = lamp_nxt[0] ? night_offset(step_nxt) : day_offset(step_nxt);
    sum      = {1'b0, base_nxt} + {1'b0, offset};
    sat      = (sum > {1'b0, duty_ceiling_r}) ? duty_ceiling_r : sum[DUTY_W-1:0];
    step_inc = step_nxt + 1'b1;
    done     = (step_inc >= RAMP_STEPS) || (step_inc == '0);

    res.duty_update     = fire;
    res.duty            = fire ? sat : '0;
    res.night_indicator = lamp_nxt[0];
    res.day_indicator   = lamp_nxt[1];
    res.busy_res        = running_nxt && !(fire && done);

    if (running_nxt) begin
      tick_nxt = fire ? '0 : tick_inc;
      if (fire) begin
        step_nxt = step_inc;
        if (done) begin
          running_nxt = 1'b0;
        end
      end
    end
  end

  // Ramp state registers advance only on an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_btn_r <= 1'b1;
      running_r  <= 1'b0;
      base_r     <= '0;
      tick_r     <= '0;
      step_r     <= '0;
      lamp_r     <= LAMPS_OFF;
    end else if (accept) begin
      prev_btn_r <= prev_btn_nxt;
      running_r  <= running_nxt;
      base_r     <= base_nxt;
      tick_r     <= tick_nxt;
      step_r     <= step_nxt;
      lamp_r     <= lamp_nxt;
    end
  end

  // Output buffer steering
  always_comb begin
    main_nxt     = main_r;
    main_vld_nxt = main_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (main_free) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        main_vld_nxt = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        main_nxt     = res;
        main_vld_nxt = accept;
      end
    end else if (accept) begin
      skid_nxt     = res;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = main_vld_r;
  assign out_ch.duty_update     = main_r.duty_update;
  assign out_ch.duty            = main_r.duty;
  assign out_ch.night_indicator = main_r.night_indicator;
  assign out_ch.day_indicator   = main_r.day_indicator;
  assign out_ch.busy_res        = main_r.busy_res;

  // The skid slot is only filled behind a waiting main slot.
  assert property (@(posedge clk) disable iff (!rst_n) skid_vld_r |-> main_vld_r)
    else $error("skid slot holds an item while the main slot is empty");

  // A running ramp always has exactly one lamp lit.
  assert property (@(posedge clk) disable iff (!rst_n) running_r |-> $onehot(lamp_r))
    else $error("running ramp without exactly one indicator lamp");

  // A running ramp never sits past its last step.
  assert property (@(posedge clk) disable iff (!rst_n) running_r |-> (step_r < RAMP_STEPS))
    else $error("ramp step index past the last step while running");

  // A result item without an update carries a zero duty.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (main_vld_r && !main_r.duty_update) |-> (main_r.duty == '0))
    else $error("nonzero duty on an item without a duty update");

  // Without a press, a running ramp stops only on an item that issues a step.
  assert property (@(posedge clk) disable iff (!rst_n)
                   (accept && running_r && !press && !running_nxt) |-> fire)
    else $error("ramp stopped without issuing its last step");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking test of the light adaptive duty ramp
// Drives tick items with random sender and receiver idling, predicts each
// result item from its own model of the ramp and compares every field.
// ----------------------------------------------------------------------------
module testbench;
  import ladr_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_PHASES   = 8;

  // Ramp offsets per step, step 0 in the low bits; steps past 10 add nothing.
  localparam logic [16*DUTY_W-1:0] NIGHT_STEP_OFS = {
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd8, 7'd10, 7'd12,
    7'd14, 7'd16, 7'd16, 7'd7, 7'd3, 7'd1, 7'd1, 7'd0};
  localparam logic [16*DUTY_W-1:0] DAY_STEP_OFS = {
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd40, 7'd45, 7'd50,
    7'd55, 7'd59, 7'd59, 7'd44, 7'd16, 7'd7, 7'd4, 7'd0};

  // Light levels on both sides of each band boundary, first entry in the low bits.
  localparam logic [8*LIGHT_W-1:0] BAND_EDGES = {
    8'd71, 8'd70, 8'd51, 8'd50, 8'd41, 8'd40, 8'd21, 8'd20};

  // Register settings of the random phases; the last phase is drawn at random.
  localparam logic [NUM_PHASES*PERIOD_W-1:0] PHASE_PERIODS = {
    8'd0, 8'd7, 8'd0, 8'd3, 8'd255, 8'd2, 8'd1, 8'd4};
  localparam logic [NUM_PHASES*DUTY_W-1:0] PHASE_CEILINGS = {
    7'd0, 7'd45, 7'd100, 7'd127, 7'd60, 7'd0, 7'd127, 7'd100};

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ladr_in_if  in_ch ();
  ladr_out_if out_ch ();

  light_adaptive_duty_ramp dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predicted ramp state and register copies
  logic                prev_button_q;
  logic                ramp_active;
  logic                night_sel;
  logic [DUTY_W-1:0]   ramp_base;
  logic [TICK_W-1:0]   tick_cnt;
  logic [STEP_W-1:0]   step_num;
  lamp_t               lamps;
  logic [PERIOD_W-1:0] period_reg;
  logic [DUTY_W-1:0]   ceiling_reg;

  ladr_res_t duty_expect_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent    = 0;
  int mismatch_count = 0;
  int cycle_count   = 0;

  always #CLK_HALF clk = ~clk;

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Advance the predicted ramp by one tick item and queue its result item.
  task automatic ramp_predict(input logic btn, input logic [LIGHT_W-1:0] light);
    ladr_res_t         res;
    logic [DUTY_W-1:0] ofs;
    int                sum;
    res = '0;
    // A falling button edge chooses the mode and restarts the ramp.
    if (prev_button_q && !btn) begin
      ramp_active = 1'b1;
      step_num    = '0;
      tick_cnt    = '0;
      if (light <= LIGHT_DUSK) begin
        night_sel = 1'b1;
        ramp_base = (light <= LIGHT_DARK) ? BASE_NIGHT_DARK : BASE_NIGHT_DUSK;
        lamps     = LAMP_NIGHT;
      end else begin
        night_sel = 1'b0;
        if (light <= LIGHT_DIM) begin
          ramp_base = BASE_DAY_DIM;
        end else if (light <= LIGHT_MID) begin
          ramp_base = BASE_DAY_MID;
        end else begin
          ramp_base = BASE_DAY_BRIGHT;
        end
        lamps = LAMP_DAY;
      end
    end
    prev_button_q = btn;

    // Issue the next saturated step once the period has elapsed.
    if (ramp_active) begin
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= period_reg) begin
        tick_cnt = '0;
        ofs = night_sel ? NIGHT_STEP_OFS[int'(step_num)*DUTY_W +: DUTY_W]
                        : DAY_STEP_OFS[int'(step_num)*DUTY_W +: DUTY_W];
        sum = int'(ramp_base) + int'(ofs);
        if (sum > int'(ceiling_reg)) begin
          sum = int'(ceiling_reg);
        end
        res.duty_update = 1'b1;
        res.duty        = sum[DUTY_W-1:0];
        step_num        = step_num + 1'b1;
        if (step_num >= RAMP_STEPS || step_num == '0) begin
          ramp_active = 1'b0;
        end
      end
    end

    res.night_indicator = lamps[0];
    res.day_indicator   = lamps[1];
    res.busy_res        = ramp_active;
    duty_expect_q.push_back(res);
  endtask

  // Send one tick item; entered and left at a falling edge.
  task automatic send_tick(input logic btn, input logic [LIGHT_W-1:0] light);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.button_level <= btn;
    in_ch.light_level  <= light;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    ramp_predict(btn, light);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result item has arrived.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (duty_expect_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  // One register write; the predictor copy follows the write.
  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
    if (idx == CFG_STEP_PERIOD) begin
      period_reg = val;
    end else begin
      ceiling_reg = val[DUTY_W-1:0];
    end
  endtask

  task automatic set_ramp_config(input logic [PERIOD_W-1:0] per,
                                 input logic [DUTY_W-1:0] ceil);
    wait_idle();
    write_reg(CFG_STEP_PERIOD, per);
    write_reg(CFG_DUTY_CEILING, {1'b0, ceil});
  endtask

  task automatic check_field(input string name, input logic [7:0] want_val,
                             input logic [7:0] got_val);
    if (want_val !== got_val) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, name, want_val, got_val);
    end
  endtask

  // Compare each accepted result item with the oldest prediction.
  always @(posedge clk) begin : result_check
    ladr_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (duty_expect_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item with nothing expected, expected none, actual duty %0d",
                 $time, out_ch.duty);
      end else begin
        want = duty_expect_q.pop_front();
        check_field("duty_update", {7'd0, want.duty_update}, {7'd0, out_ch.duty_update});
        check_field("duty", {1'b0, want.duty}, {1'b0, out_ch.duty});
        check_field("night_indicator", {7'd0, want.night_indicator},
                    {7'd0, out_ch.night_indicator});
        check_field("day_indicator", {7'd0, want.day_indicator},
                    {7'd0, out_ch.day_indicator});
        check_field("busy_res", {7'd0, want.busy_res}, {7'd0, out_ch.busy_res});
      end
    end
  end

  // Ramp under the reset register values: one step after four ticks.
  task automatic test_reset_config();
    send_tick(1'b1, 8'hA5);
    send_tick(1'b0, 8'd0);
    repeat (4) send_tick(1'b0, 8'h5A);
  endtask

  // Every light band with zero period and a ceiling above one hundred;
  // each press lands on a running ramp, the last one runs to its final step.
  task automatic test_light_bands();
    logic [LIGHT_W-1:0] light;
    set_ramp_config(8'd0, 7'd127);
    for (int i = 0; i < 8; i++) begin
      light = BAND_EDGES[i*LIGHT_W +: LIGHT_W];
      send_tick(1'b1, ~light);
      send_tick(1'b0, light);
    end
    repeat (10) send_tick(1'b0, LIGHT_W'($urandom_range(255)));
  endtask

  // A ceiling of zero holds every issued duty at zero.
  task automatic test_ceiling_floor();
    set_ramp_config(8'd1, 7'd0);
    send_tick(1'b1, 8'hFF);
    send_tick(1'b0, 8'd255);
    send_tick(1'b0, 8'd0);
  endtask

  // One random press sequence, or a burst of noise.
  task automatic random_sequence(input logic [PERIOD_W-1:0] per, input int left);
    int                 hold;
    int                 span;
    int                 edge_idx;
    logic [LIGHT_W-1:0] light;
    if ($urandom_range(99) < 80) begin
      repeat ($urandom_range(1, 3)) send_tick(1'b1, LIGHT_W'($urandom_range(255)));
      if ($urandom_range(1)) begin
        light = LIGHT_W'($urandom_range(255));
      end else begin
        edge_idx = $urandom_range(7);
        light = BAND_EDGES[edge_idx*LIGHT_W +: LIGHT_W];
      end
      send_tick(1'b0, light);
      // Hold the button for a random number of ticks, at most a full ramp plus four;
      // a rare bounce restarts the ramp.
      span = 11 * ((per == '0) ? 1 : int'(per)) + 4;
      hold = $urandom_range(span);
      if (hold > left) begin
        hold = left;
      end
      repeat (hold) begin
        if ($urandom_range(99) < 2) begin
          send_tick(1'b1, LIGHT_W'($urandom_range(255)));
        end else begin
          send_tick(1'b0, LIGHT_W'($urandom_range(255)));
        end
      end
    end else begin
      repeat ($urandom_range(1, 8)) begin
        send_tick(1'($urandom_range(1)), LIGHT_W'($urandom_range(255)));
      end
    end
  endtask

  // Random phases over several register settings and idling patterns.
  task automatic test_random_ramps();
    int                  phase_end;
    logic [PERIOD_W-1:0] per;
    logic [DUTY_W-1:0]   ceil;
    for (int p = 0; p < NUM_PHASES; p++) begin
      per  = PHASE_PERIODS[p*PERIOD_W +: PERIOD_W];
      ceil = PHASE_CEILINGS[p*DUTY_W +: DUTY_W];
      if (p == NUM_PHASES - 1) begin
        per  = PERIOD_W'($urandom_range(1, 16));
        ceil = DUTY_W'($urandom_range(127));
      end
      set_ramp_config(per, ceil);
      if (p < 3) begin
        send_idle_pct = 7;
        recv_idle_pct = 83;
      end else if (p < 6) begin
        send_idle_pct = 83;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_end = ticks_sent + ((per == 8'd255) ? 560 : 150);
      while (ticks_sent < phase_end) begin
        random_sequence(per, phase_end - ticks_sent);
      end
    end
  endtask

  // Main sequence
  initial begin
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = CFG_STEP_PERIOD;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.button_level = 1'b1;
    in_ch.light_level  = '0;

    prev_button_q = 1'b1;
    ramp_active   = 1'b0;
    night_sel     = 1'b0;
    ramp_base     = '0;
    tick_cnt      = '0;
    step_num      = '0;
    lamps         = LAMPS_OFF;
    period_reg    = STEP_PERIOD_RST;
    ceiling_reg   = DUTY_CEILING_RST;
    send_idle_pct = 7;
    recv_idle_pct = 83;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_config();
    test_light_bands();
    test_ceiling_floor();
    test_random_ramps();

    wait_idle();
    mismatch_count += duty_expect_q.size();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== light_adaptive_duty_ramp.f =====
src/ladr_pkg.sv
src/ladr_if.sv
src/light_adaptive_duty_ramp.sv
test/testbench.sv
